@@ src/tte_pkg.sv @@
package tte_pkg;

    localparam int KIND_W    = 3;
    localparam int ID_W      = 6;
    localparam int TMO_W     = 24;
    localparam int ELAP_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int TIME_W    = 32;
    localparam int MAX_FIRES = 32;
    localparam int FCNT_W    = 6;
    localparam int IN_W      = 56;
    localparam int OUT_W     = 40;

    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADJUST = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIRE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ID    = 2'd2;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_ADJUST,
        OP_FIRE,
        OP_TICK,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              bad_id;
        logic [ID_W-1:0]   id;
        logic [TMO_W-1:0]  timeout;
        logic [ELAP_W-1:0] elapsed;
    } item_t;

    typedef struct packed {
        logic              en;
        logic [ID_W-1:0]   idx;
        logic [TIME_W-1:0] expiry;
        logic [TIME_W-1:0] order;
    } mem_wr_t;

    typedef struct packed {
        logic start;
        logic only_due;
    } scan_ctl_t;

    typedef struct packed {
        logic                     done;
        logic                     found;
        logic [ID_W-1:0]          best_idx;
        logic signed [TIME_W-1:0] best_d;
    } scan_res_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FIRE_OUT,
        BK_SCAN,
        BK_SUM_SCAN,
        BK_SUM_OUT
    } bk_state_t;

endpackage

@@ src/tte_front.sv @@
module tte_front #(
    parameter int TABLE_SIZE = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [tte_pkg::IN_W-1:0]   s_data,
    output logic                       q_valid,
    input  logic                       q_pop,
    output tte_pkg::item_t             q_item
);
    import tte_pkg::*;

    item_t             slot_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        cnt_reg;
    item_t             cls;
    logic [KIND_W-1:0] kind;
    logic              push, pop;

    assign kind = s_data[2:0];

    always_comb
    begin
        cls.id      = s_data[8:3];
        cls.timeout = s_data[32:9];
        cls.elapsed = s_data[48:33];
        cls.bad_id  = (kind <= KIND_FIRE) && (cls.id >= ID_W'(TABLE_SIZE));
        unique case (kind)
            KIND_ADD:    cls.op = OP_ADD;
            KIND_ADJUST: cls.op = OP_ADJUST;
            KIND_FIRE:   cls.op = OP_FIRE;
            KIND_TICK:   cls.op = OP_TICK;
            KIND_CLEAR:  cls.op = OP_CLEAR;
            default:     cls.op = OP_NOP;
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ src/tte_scan.sv @@
module tte_scan #(
    parameter int TABLE_SIZE = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tte_pkg::mem_wr_t                  wr,
    input  tte_pkg::scan_ctl_t                ctl,
    input  logic [TABLE_SIZE-1:0]             armed,
    input  logic [tte_pkg::TIME_W-1:0]        now_ms,
    input  logic [tte_pkg::TIME_W-1:0]        order_cnt,
    output tte_pkg::scan_res_t                res
);
    import tte_pkg::*;

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    logic [2*TIME_W-1:0]      mem [TABLE_SIZE];
    logic [2*TIME_W-1:0]      rd_reg;
    logic                     issue_reg;
    logic [IDX_W-1:0]         issue_idx_reg;
    logic                     p1_valid_reg, p1_last_reg;
    logic [IDX_W-1:0]         p1_idx_reg;
    logic                     p2_valid_reg, p2_last_reg;
    logic [IDX_W-1:0]         p2_idx_reg;
    logic signed [TIME_W-1:0] d_reg;
    logic [TIME_W-1:0]        age_reg;
    logic                     found_reg, done_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic signed [TIME_W-1:0] best_d_reg;
    logic [TIME_W-1:0]        best_age_reg;
    logic                     take;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx[IDX_W-1:0]] <= {wr.expiry, wr.order};
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg  <= mem[issue_idx_reg];
        p1_idx_reg <= issue_idx_reg;
        // distance from now (signed) and age relative to the order counter
        d_reg   <= rd_reg[2*TIME_W-1:TIME_W] - now_ms;
        age_reg <= order_cnt - rd_reg[TIME_W-1:0];
        p2_idx_reg <= p1_idx_reg;
    end

    assign take = p2_valid_reg && armed[p2_idx_reg]
                  && (!ctl.only_due || d_reg <= 0)
                  && (!found_reg || d_reg < best_d_reg
                      || (d_reg == best_d_reg && age_reg > best_age_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg     <= 1'b0;
            issue_idx_reg <= '0;
            p1_valid_reg  <= 1'b0;
            p1_last_reg   <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p2_last_reg   <= 1'b0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= issue_reg;
            p1_last_reg  <= issue_reg && (issue_idx_reg == IDX_W'(TABLE_SIZE - 1));
            p2_valid_reg <= p1_valid_reg;
            p2_last_reg  <= p1_last_reg;
            done_reg     <= p2_valid_reg && p2_last_reg;
            if (ctl.start)
            begin
                issue_reg     <= 1'b1;
                issue_idx_reg <= '0;
                found_reg     <= 1'b0;
            end
            else
            begin
                if (issue_reg)
                begin
                    if (issue_idx_reg == IDX_W'(TABLE_SIZE - 1))
                    begin
                        issue_reg <= 1'b0;
                    end
                    else
                    begin
                        issue_idx_reg <= issue_idx_reg + 1'b1;
                    end
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg <= p2_idx_reg;
            best_d_reg   <= d_reg;
            best_age_reg <= age_reg;
        end
    end

    assign res.done     = done_reg;
    assign res.found    = found_reg;
    assign res.best_idx = ID_W'(best_idx_reg);
    assign res.best_d   = best_d_reg;

endmodule

@@ src/tte_back.sv @@
module tte_back #(
    parameter int TABLE_SIZE = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    output logic                       q_pop,
    input  tte_pkg::item_t             q_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_fire,
    output logic                       out_last,
    output logic [tte_pkg::OUT_W-1:0]  out_data
);
    import tte_pkg::*;

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    bk_state_t           state_reg, state_next;
    logic [TABLE_SIZE-1:0] armed_reg;
    logic [TIME_W-1:0]   now_reg, order_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                only_due_reg, chain_reg;
    logic [ID_W-1:0]     fire_id_reg;
    logic [FCNT_W-1:0]   fire_cnt_reg;
    logic                out_valid_reg, out_fire_reg, out_last_reg;
    logic [OUT_W-1:0]    out_data_reg;

    logic                out_free, id_armed;
    logic                arm_go, fire_load, sum_load;
    mem_wr_t             wr;
    scan_ctl_t           ctl;
    scan_res_t           res;
    logic [TMO_W-1:0]    delay;

    assign out_free = !out_valid_reg || out_ready;
    assign id_armed = armed_reg[q_item.id[IDX_W-1:0]];

    tte_scan #(.TABLE_SIZE(TABLE_SIZE)) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .ctl      (ctl),
        .armed    (armed_reg),
        .now_ms   (now_reg),
        .order_cnt(order_reg),
        .res      (res)
    );

    assign wr.en     = arm_go;
    assign wr.idx    = q_item.id;
    assign wr.expiry = now_reg + TIME_W'(q_item.timeout);
    assign wr.order  = order_reg;

    // no armed entry or already due: zero delay
    always_comb
    begin
        if (!res.found || res.best_d <= 0)
        begin
            delay = '0;
        end
        else if (res.best_d[TIME_W-1:TMO_W] != '0)
        begin
            delay = '1;
        end
        else
        begin
            delay = res.best_d[TMO_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        arm_go     = 1'b0;
        fire_load  = 1'b0;
        sum_load   = 1'b0;
        ctl.start  = 1'b0;
        ctl.only_due = only_due_reg && (state_reg == BK_SCAN);
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    ctl.start = 1'b1;
                    state_next = BK_SUM_SCAN;
                    if (!q_item.bad_id)
                    begin
                        unique case (q_item.op)
                            OP_ADD:    arm_go = 1'b1;
                            OP_ADJUST: arm_go = id_armed;
                            OP_FIRE:
                            begin
                                if (id_armed)
                                begin
                                    ctl.start  = 1'b0;
                                    state_next = BK_FIRE_OUT;
                                end
                            end
                            OP_TICK, OP_CLEAR: state_next = BK_SCAN;
                            default: ;
                        endcase
                    end
                end
            end
            BK_SCAN:
            begin
                if (res.done)
                begin
                    if (res.found && fire_cnt_reg < FCNT_W'(MAX_FIRES))
                    begin
                        state_next = BK_FIRE_OUT;
                    end
                    else
                    begin
                        ctl.start  = 1'b1;
                        state_next = BK_SUM_SCAN;
                    end
                end
            end
            BK_FIRE_OUT:
            begin
                if (out_free)
                begin
                    fire_load  = 1'b1;
                    ctl.start  = 1'b1;
                    state_next = chain_reg ? BK_SCAN : BK_SUM_SCAN;
                end
            end
            BK_SUM_SCAN:
            begin
                if (res.done)
                begin
                    state_next = BK_SUM_OUT;
                end
            end
            BK_SUM_OUT:
            begin
                if (out_free)
                begin
                    sum_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            armed_reg     <= '0;
            now_reg       <= '0;
            order_reg     <= '0;
            status_reg    <= ST_OK;
            only_due_reg  <= 1'b0;
            chain_reg     <= 1'b0;
            fire_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire_load || sum_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (arm_go)
            begin
                armed_reg[q_item.id[IDX_W-1:0]] <= 1'b1;
                order_reg <= order_reg + 1'b1;
            end
            if (fire_load)
            begin
                armed_reg[fire_id_reg[IDX_W-1:0]] <= 1'b0;
                fire_cnt_reg <= fire_cnt_reg + 1'b1;
            end
            if (sum_load)
            begin
                status_reg <= ST_OK;
            end
            if (state_reg == BK_SCAN && state_next == BK_FIRE_OUT)
            begin
                chain_reg <= 1'b1;
            end
            if (state_reg == BK_IDLE && q_valid)
            begin
                fire_cnt_reg <= '0;
                chain_reg    <= 1'b0;
                only_due_reg <= (q_item.op == OP_TICK);
                if (q_item.bad_id)
                begin
                    status_reg <= ST_BAD_ID;
                end
                else if (q_item.op == OP_ADJUST && !id_armed)
                begin
                    status_reg <= ST_NOT_FOUND;
                end
                if (!q_item.bad_id && q_item.op == OP_TICK)
                begin
                    now_reg <= now_reg + TIME_W'(q_item.elapsed);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_IDLE)
        begin
            fire_id_reg <= q_item.id;
        end
        else if (state_reg == BK_SCAN && res.done)
        begin
            fire_id_reg <= res.best_idx;
        end
        if (fire_load)
        begin
            out_fire_reg <= 1'b1;
            out_last_reg <= 1'b0;
            out_data_reg <= OUT_W'(fire_id_reg);
        end
        else if (sum_load)
        begin
            out_fire_reg <= 1'b0;
            out_last_reg <= 1'b1;
            out_data_reg <= OUT_W'({delay, res.found, status_reg, {ID_W{1'b0}}});
        end
    end

    assign out_valid = out_valid_reg;
    assign out_fire  = out_fire_reg;
    assign out_last  = out_last_reg;
    assign out_data  = out_data_reg;

    a_fire_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        fire_load |=> !armed_reg[$past(fire_id_reg[IDX_W-1:0])])
        else $error("fired id still armed");

    a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        res.done |-> (state_reg == BK_SCAN || state_reg == BK_SUM_SCAN))
        else $error("scan finished outside a scan state");

    a_sum_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        sum_load |=> (out_valid_reg && out_last_reg && !out_fire_reg))
        else $error("summary not presented as last");

    a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fire_load |-> fire_cnt_reg < FCNT_W'(MAX_FIRES))
        else $error("too many fires in one transaction");

endmodule

@@ src/timeout_table_engine_unit.sv @@
// Ordered timeout table: add, adjust, fire, tick and clear transactions on the slave
// stream; each produces zero or more fired-id results (tuser=1) and then one summary
// (tlast=1) with status, armed flag and delay to the next expiry. Items are processed
// one at a time. Every scan reads the table one entry at a time through the single
// read port of the expiry/order memory: add, adjust, fire and no-op items need one
// summary scan, tick and clear need F+2 scans for F fired ids. A two-entry input
// queue accepts further items while one is in progress.
module timeout_table_engine_unit #(
    parameter int TABLE_SIZE = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // kind[2:0], timer_id[8:3], timeout_ms[32:9], elapsed_ms[48:33]
    input  logic [tte_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // fired_id[5:0], status[7:6], has_timer[8], next_delay_ms[32:9]
    output logic [tte_pkg::OUT_W-1:0]  m_axis_tdata,
    // is_fire[0]
    output logic                       m_axis_tuser,
    output logic                       m_axis_tlast
);
    import tte_pkg::*;

    logic  q_valid, q_pop;
    item_t q_item;

    tte_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .s_valid(s_axis_tvalid),
        .s_ready(s_axis_tready),
        .s_data (s_axis_tdata),
        .q_valid(q_valid),
        .q_pop  (q_pop),
        .q_item (q_item)
    );

    tte_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_fire (m_axis_tuser),
        .out_last (m_axis_tlast),
        .out_data (m_axis_tdata)
    );

endmodule
